// ===== hdl/ric_pkg.sv =====
// Shared types, codes and sizes of the inode slot cache.
`default_nettype none
package ric_pkg;

   localparam int SLOT_COUNT   = 16;
   localparam int SLOT_IW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_FIELD_W = 4;
   localparam int INODE_W      = 16;
   localparam int REFS_W       = 16;
   localparam int LIMIT_W      = 17;

   localparam logic [REFS_W-1:0]  REFS_MAX    = '1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

   // request kinds
   localparam logic [1:0] KIND_GET  = 2'd0;
   localparam logic [1:0] KIND_PUT  = 2'd1;
   localparam logic [1:0] KIND_SYNC = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_INODE   = 3'd1;
   localparam logic [2:0] ST_NO_SLOT    = 3'd2;
   localparam logic [2:0] ST_PUT_ZERO   = 3'd3;
   localparam logic [2:0] ST_COUNT_FULL = 3'd4;

   // result action codes
   localparam logic [1:0] ACT_NONE      = 2'd0;
   localparam logic [1:0] ACT_WRITEBACK = 2'd1;
   localparam logic [1:0] ACT_RECLAIM   = 2'd2;
   localparam logic [1:0] ACT_LOAD      = 2'd3;

   // result kinds the controller asks the datapath to produce
   localparam logic [3:0] EM_BAD       = 4'd0;
   localparam logic [3:0] EM_FULL      = 4'd1;
   localparam logic [3:0] EM_HIT       = 4'd2;
   localparam logic [3:0] EM_NOSLOT    = 4'd3;
   localparam logic [3:0] EM_VICTIM    = 4'd4;
   localparam logic [3:0] EM_LOAD      = 4'd5;
   localparam logic [3:0] EM_PUT       = 4'd6;
   localparam logic [3:0] EM_SYNC_SLOT = 4'd7;
   localparam logic [3:0] EM_DONE      = 4'd8;
   localparam logic [3:0] EM_ZERO      = 4'd9;

   // slot pointer operations
   localparam logic [2:0] SEL_HOLD = 3'd0;
   localparam logic [2:0] SEL_GET  = 3'd1;
   localparam logic [2:0] SEL_PUT  = 3'd2;
   localparam logic [2:0] SEL_ZERO = 3'd3;
   localparam logic [2:0] SEL_NEXT = 3'd4;

   typedef struct packed {
      logic [1:0]         kind;
      logic [INODE_W-1:0] inode_number;
      logic               allocated;
      logic [3:0]         slot_index;
      logic               put_dirty;
      logic               put_unlinked;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [1:0]              action;
      logic [INODE_W-1:0]      action_inode;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic       take;
      logic       match;
      logic [2:0] sel_op;
      logic       emit;
      logic [3:0] emit_code;
   } dp_cmd_type;

   typedef struct packed {
      logic bad;
      logic hit;
      logic victim;
      logic full;
      logic victim_act;
      logic scan_act;
      logic scan_end;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== hdl/ric_datapath.sv =====
// Slot table, lookup vectors, slot pointer and result register of the inode slot cache.
`default_nettype none
module ric_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ric_pkg::req_type              req_data,
   input  wire logic                          csr_valid,
   input  wire logic [ric_pkg::LIMIT_W-1:0]   csr_data,
   input  wire ric_pkg::dp_cmd_type           cmd,
   output ric_pkg::dp_stat_type               stat,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output ric_pkg::rsp_type                   rsp_data
);
   import ric_pkg::*;

   function automatic logic [SLOT_IW-1:0] lowest(input logic [SLOT_COUNT-1:0] vec);
      logic [SLOT_IW-1:0] idx;
      idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = SLOT_IW'(i);
         end
      end
      return idx;
   endfunction

   logic [LIMIT_W-1:0]    limit_ff;
   req_type               item_ff;
   logic [INODE_W-1:0]    inode_ff [SLOT_COUNT];
   logic [INODE_W-1:0]    inode_in [SLOT_COUNT];
   logic [REFS_W-1:0]     refs_ff  [SLOT_COUNT];
   logic [REFS_W-1:0]     refs_in  [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] dirty_ff, dirty_in;
   logic [SLOT_COUNT-1:0] unl_ff, unl_in;
   logic [SLOT_COUNT-1:0] hit_vec_ff, hit_vec_in;
   logic [SLOT_COUNT-1:0] empty_vec_ff, empty_vec_in;
   logic [SLOT_COUNT-1:0] idle_vec_ff, idle_vec_in;
   logic                  bad_ff, bad_in;
   logic [SLOT_IW-1:0]    sel_ff, sel_in;
   logic                  hit_ff, hit_in;
   logic                  victim_ff, victim_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [INODE_W-1:0]    cur_inode;
   logic [REFS_W-1:0]     cur_refs;
   logic                  cur_dirty;
   logic                  cur_unl;
   logic                  put_oob;
   logic [REFS_W-1:0]     put_refs;
   logic                  out_free;

   assign cur_inode = inode_ff[sel_ff];
   assign cur_refs  = refs_ff[sel_ff];
   assign cur_dirty = dirty_ff[sel_ff];
   assign cur_unl   = unl_ff[sel_ff];
   assign put_oob   = 32'(item_ff.slot_index) >= 32'(SLOT_COUNT);
   assign put_refs  = cur_refs - REFS_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // parallel tag compare against the held request
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit_vec_in[i]   = inode_ff[i] == item_ff.inode_number;
         empty_vec_in[i] = inode_ff[i] == '0;
         idle_vec_in[i]  = (inode_ff[i] != '0) && (refs_ff[i] == '0);
      end
      bad_in = (item_ff.inode_number == '0)
            || ({1'b0, item_ff.inode_number} >= limit_ff)
            || !item_ff.allocated;
   end

   // slot pointer: for a get, hit first, else lowest empty, else lowest unreferenced; else put index, zero or next
   always_comb begin
      sel_in    = sel_ff;
      hit_in    = hit_ff;
      victim_in = victim_ff;
      case (cmd.sel_op)
         SEL_GET: begin
            hit_in    = |hit_vec_ff;
            victim_in = |empty_vec_ff || |idle_vec_ff;
            if (|hit_vec_ff) begin
               sel_in = lowest(hit_vec_ff);
            end else if (|empty_vec_ff) begin
               sel_in = lowest(empty_vec_ff);
            end else begin
               sel_in = lowest(idle_vec_ff);
            end
         end
         SEL_PUT:  sel_in = SLOT_IW'(item_ff.slot_index);
         SEL_ZERO: sel_in = '0;
         SEL_NEXT: sel_in = sel_ff + SLOT_IW'(1);
         default:  sel_in = sel_ff;
      endcase
   end

   // result formation and table update
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         inode_in[i] = inode_ff[i];
         refs_in[i]  = refs_ff[i];
      end
      dirty_in = dirty_ff;
      unl_in   = unl_ff;

      rsp_in.status       = ST_OK;
      rsp_in.slot         = SLOT_FIELD_W'(sel_ff);
      rsp_in.action       = ACT_NONE;
      rsp_in.action_inode = item_ff.inode_number;
      rsp_in.last         = 1'b1;

      if (cmd.emit) begin
         unique case (cmd.emit_code)
            EM_BAD: begin
               rsp_in.status = ST_NO_INODE;
               rsp_in.slot   = '0;
            end
            EM_FULL: rsp_in.status = ST_COUNT_FULL;
            EM_HIT:  refs_in[sel_ff] = cur_refs + REFS_W'(1);
            EM_NOSLOT: begin
               rsp_in.status = ST_NO_SLOT;
               rsp_in.slot   = '0;
            end
            EM_VICTIM: begin
               rsp_in.action       = cur_unl ? ACT_RECLAIM : ACT_WRITEBACK;
               rsp_in.action_inode = cur_inode;
               rsp_in.last         = 1'b0;
            end
            EM_LOAD: begin
               rsp_in.action    = ACT_LOAD;
               inode_in[sel_ff] = item_ff.inode_number;
               refs_in[sel_ff]  = REFS_W'(1);
               dirty_in[sel_ff] = 1'b0;
               unl_in[sel_ff]   = 1'b0;
            end
            EM_PUT: begin
               rsp_in.slot = SLOT_FIELD_W'(item_ff.slot_index);
               if (put_oob) begin
                  rsp_in.status       = ST_PUT_ZERO;
                  rsp_in.action_inode = '0;
               end else if (cur_refs == '0) begin
                  rsp_in.status       = ST_PUT_ZERO;
                  rsp_in.action_inode = cur_inode;
               end else begin
                  rsp_in.action_inode = cur_inode;
                  if (put_refs == '0 && item_ff.put_unlinked) begin
                     rsp_in.action    = ACT_RECLAIM;
                     inode_in[sel_ff] = '0;
                     refs_in[sel_ff]  = '0;
                     dirty_in[sel_ff] = 1'b0;
                     unl_in[sel_ff]   = 1'b0;
                  end else begin
                     refs_in[sel_ff]  = put_refs;
                     dirty_in[sel_ff] = cur_dirty | item_ff.put_dirty;
                     unl_in[sel_ff]   = item_ff.put_unlinked;
                  end
               end
            end
            EM_SYNC_SLOT: begin
               rsp_in.action_inode = cur_inode;
               rsp_in.last         = 1'b0;
               if (cur_refs == '0 && cur_unl) begin
                  rsp_in.action    = ACT_RECLAIM;
                  inode_in[sel_ff] = '0;
                  refs_in[sel_ff]  = '0;
                  dirty_in[sel_ff] = 1'b0;
                  unl_in[sel_ff]   = 1'b0;
               end else begin
                  rsp_in.action    = ACT_WRITEBACK;
                  dirty_in[sel_ff] = 1'b0;
               end
            end
            EM_DONE, EM_ZERO: begin
               rsp_in.slot         = '0;
               rsp_in.action_inode = '0;
            end
            default: rsp_in.last = 1'b1;
         endcase
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         dirty_ff     <= '0;
         unl_ff       <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            inode_ff[i] <= '0;
            refs_ff[i]  <= '0;
         end
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         dirty_ff     <= dirty_in;
         unl_ff       <= unl_in;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            inode_ff[i] <= inode_in[i];
            refs_ff[i]  <= refs_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_ff <= req_data;
      end
      if (cmd.match) begin
         hit_vec_ff   <= hit_vec_in;
         empty_vec_ff <= empty_vec_in;
         idle_vec_ff  <= idle_vec_in;
         bad_ff       <= bad_in;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
      sel_ff    <= sel_in;
      hit_ff    <= hit_in;
      victim_ff <= victim_in;
   end

   assign stat.bad        = bad_ff;
   assign stat.hit        = hit_ff;
   assign stat.victim     = victim_ff;
   assign stat.full       = cur_refs >= REFS_MAX;
   assign stat.victim_act = (cur_inode != '0) && (cur_unl || cur_dirty);
   assign stat.scan_act   = (cur_inode != '0) && ((cur_refs == '0 && cur_unl) || cur_dirty);
   assign stat.scan_end   = sel_ff == SLOT_IW'(SLOT_COUNT - 1);
   assign stat.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hdl/ric_control.sv =====
// Sequencing state machine of the inode slot cache.
`default_nettype none
module ric_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_kind,
   output logic                       req_ready,
   input  wire ric_pkg::dp_stat_type  stat,
   output ric_pkg::dp_cmd_type        cmd
);
   import ric_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MATCH  = 3'd1;
   localparam logic [2:0] S_PICK   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_VICTIM = 3'd4;
   localparam logic [2:0] S_PUT    = 3'd5;
   localparam logic [2:0] S_SCAN   = 3'd6;
   localparam logic [2:0] S_FINAL  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [3:0] code_ff, code_in;

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               unique case (req_kind)
                  KIND_GET:  state_in = S_MATCH;
                  KIND_PUT:  state_in = S_PUT;
                  KIND_SYNC: begin
                     cmd.sel_op = SEL_ZERO;
                     state_in   = S_SCAN;
                  end
                  default: begin
                     code_in  = EM_ZERO;
                     state_in = S_FINAL;
                  end
               endcase
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_PICK;
         end
         S_PICK: begin
            cmd.sel_op = SEL_GET;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_FINAL;
            if (stat.bad) begin
               code_in = EM_BAD;
            end else if (stat.hit) begin
               code_in = stat.full ? EM_FULL : EM_HIT;
            end else if (!stat.victim) begin
               code_in = EM_NOSLOT;
            end else if (stat.victim_act) begin
               state_in = S_VICTIM;
            end else begin
               code_in = EM_LOAD;
            end
         end
         S_VICTIM: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = EM_VICTIM;
               code_in       = EM_LOAD;
               state_in      = S_FINAL;
            end
         end
         S_PUT: begin
            cmd.sel_op = SEL_PUT;
            code_in    = EM_PUT;
            state_in   = S_FINAL;
         end
         S_SCAN: begin
            // wait only when this slot has something to report
            if (!stat.scan_act || stat.out_free) begin
               cmd.emit      = stat.scan_act;
               cmd.emit_code = EM_SYNC_SLOT;
               if (stat.scan_end) begin
                  code_in  = EM_DONE;
                  state_in = S_FINAL;
               end else begin
                  cmd.sel_op = SEL_NEXT;
               end
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = code_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= EM_ZERO;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/refcounted_inode_slot_cache_unit.sv =====
// Top level of the reference-counted inode slot cache.
`default_nettype none
// A get passes the match, pick and decide states, with a victim result first when a victim is
// written back or reclaimed; a put passes the put state, an unknown kind goes to its result at once,
// and a sync walks one slot per cycle, waiting on a slot with a result while the result side stalls.
// One request is in flight; the next is taken once the last result is formed. Synchronous
// active-high reset empties every slot, sets the inode limit to 65536 and drops any pending result.
module refcounted_inode_slot_cache_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire ric_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output ric_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [ric_pkg::LIMIT_W-1:0] csr_data
);
   import ric_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Limit register always ready; user writes must come only while idle, unchecked by the block.
   assign csr_ready = 1'b1;

   // Controller: walks lookup, victim selection, put and the sync scan, and decides
   // which result the datapath forms next.
   ric_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: holds the slot table, compares all tags in parallel, encodes the chosen
   // slot into a pointer and keeps the result in a register that the result side drains.
   ric_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
